// ----- rtl/core/key_value_string_lookup_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the key/value string lookup block
// Both macros expect signals named clk and arst_n in the calling scope.
// ---------------------------------------------------------------------------
`ifndef KEY_VALUE_STRING_LOOKUP_ASSERT_SVH
`define KEY_VALUE_STRING_LOOKUP_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define KVSL_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("kvsl assertion failed");

// Antecedent implies consequent in the following cycle.
`define KVSL_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("kvsl assertion failed");

`endif

// ----- rtl/core/kvsl_pkg.sv -----
// ---------------------------------------------------------------------------
// kvsl_pkg
// Types, constants and helper functions shared by the lookup block.
// ---------------------------------------------------------------------------
package kvsl_pkg;

	localparam int KEY_MAX_CHARS = 8;
	localparam int KEY_IDX_W     = (KEY_MAX_CHARS > 1) ? $clog2(KEY_MAX_CHARS) : 1;
	localparam int KEY_POS_W     = 4;
	localparam int KEY_CHARS_W   = 64;
	localparam int CFG_DATA_W    = 64;

	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_EQ    = 8'h3D;
	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_CR    = 8'h0D;

	typedef enum logic [1:0] {
		REG_LOOKUP_MODE = 2'd0,
		REG_KEY_CHARS   = 2'd1,
		REG_KEY_LENGTH  = 2'd2,
		REG_VALUE_LIMIT = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_HEAD  = 3'd0,
		PH_COMMA = 3'd1,
		PH_KEY   = 3'd2,
		PH_EQ    = 3'd3,
		PH_VALUE = 3'd4,
		PH_EMIT  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CL_SPACE = 2'd0,
		CL_COMMA = 2'd1,
		CL_EQ    = 2'd2,
		CL_WORD  = 2'd3
	} char_class_t;

	typedef struct packed {
		logic                   lookup_mode;
		logic [KEY_CHARS_W-1:0] key_chars;
		logic [3:0]             key_length;
		logic [7:0]             value_limit;
	} cfg_t;

	typedef struct packed {
		logic [7:0] value_byte;
		logic       byte_valid;
		logic       found;
		logic       is_last;
	} result_t;

	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cl;
		if (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR))
			cl = CL_SPACE;
		else if (c == CHAR_COMMA)
			cl = CL_COMMA;
		else if (c == CHAR_EQ)
			cl = CL_EQ;
		else
			cl = CL_WORD;
		return cl;
	endfunction

	// Key length with values above the key capacity clamped to it.
	function automatic logic [KEY_POS_W-1:0] key_len_eff(input logic [3:0] len);
		logic [KEY_POS_W-1:0] k;
		if (len > 4'(KEY_MAX_CHARS))
			k = KEY_POS_W'(KEY_MAX_CHARS);
		else
			k = KEY_POS_W'(len);
		return k;
	endfunction

	function automatic logic [7:0] key_byte(input logic [KEY_CHARS_W-1:0] key,
			input logic [KEY_IDX_W-1:0] idx);
		return key[8*idx +: 8];
	endfunction

endpackage

// ----- rtl/core/key_value_string_lookup.sv -----
// ---------------------------------------------------------------------------
// key_value_string_lookup
// Looks up a key in a "head, key = value, ..." string, one character a beat.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  in        receive    in_valid / in_stall    text_char, end_of_text
//  out       send       out_valid / out_stall  value_byte, byte_valid, found, is_last
//  cfg       receive    cfg_wr_en              cfg_index, cfg_data
//
// One character is taken every cycle unless in_stall is raised; a result passes through
// the input register, then the result register, before it is on the output.
// The parse step is combinational logic between the two registers.
// A stall on the output holds the result register and, in the same cycle,
// raises in_stall once the input register is also full.
// Reset needs no warm-up; the block takes characters as soon as reset is released.
// ---------------------------------------------------------------------------
module key_value_string_lookup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [7:0]                      text_char,
	input  logic                            end_of_text,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [7:0]                      value_byte,
	output logic                            byte_valid,
	output logic                            found,
	output logic                            is_last,
	input  logic                            cfg_wr_en,
	input  logic [1:0]                      cfg_index,
	input  logic [kvsl_pkg::CFG_DATA_W-1:0] cfg_data
);

	kvsl_pkg::cfg_t    cfg;
	kvsl_pkg::result_t res;
	logic              res_vld;
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eot_s1;
	logic              advance;
	logic              accept;

	// The parse step may run whenever the result register is free or draining.
	assign advance  = !out_valid || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1 <= text_char;
			eot_s1  <= end_of_text;
		end
	end

	kvsl_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kvsl_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && advance),
		.ch      (char_s1),
		.eot     (eot_s1),
		.cfg     (cfg),
		.res_vld (res_vld),
		.res     (res)
	);

	kvsl_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (valid_s1 && advance && res_vld),
		.res        (res),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.value_byte (value_byte),
		.byte_valid (byte_valid),
		.found      (found),
		.is_last    (is_last)
	);

endmodule

// ----- rtl/core/kvsl_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// kvsl_cfg_regs
// Configuration register file written through a plain write port.
// ---------------------------------------------------------------------------
module kvsl_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [1:0]                     cfg_index,
	input  logic [kvsl_pkg::CFG_DATA_W-1:0] cfg_data,
	output kvsl_pkg::cfg_t                 cfg
);

	kvsl_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lookup_mode <= 1'b0;
			cfg_q.key_chars   <= '0;
			cfg_q.key_length  <= 4'd1;
			cfg_q.value_limit <= 8'd255;
		end else if (cfg_wr_en) begin
			unique case (kvsl_pkg::cfg_reg_t'(cfg_index))
				kvsl_pkg::REG_LOOKUP_MODE: cfg_q.lookup_mode <= cfg_data[0];
				kvsl_pkg::REG_KEY_CHARS:   cfg_q.key_chars   <= cfg_data[kvsl_pkg::KEY_CHARS_W-1:0];
				kvsl_pkg::REG_KEY_LENGTH:  cfg_q.key_length  <= cfg_data[3:0];
				kvsl_pkg::REG_VALUE_LIMIT: cfg_q.value_limit <= cfg_data[7:0];
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/kvsl_parser.sv -----
// ---------------------------------------------------------------------------
// kvsl_parser
// Tokenizer and grammar state machine; one character per enabled cycle.
// ---------------------------------------------------------------------------
module kvsl_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          ch,
	input  logic                eot,
	input  kvsl_pkg::cfg_t      cfg,
	output logic                res_vld,
	output kvsl_pkg::result_t   res
);

	kvsl_pkg::phase_t                  phase_q, phase_n;
	logic                              in_word_q, in_word_n;
	logic [kvsl_pkg::KEY_POS_W-1:0]    key_pos_q, key_pos_n;
	logic                              key_eq_q, key_eq_n;
	logic                              matched_q, matched_n;
	logic [7:0]                        emitted_q, emitted_n;
	logic                              finished_q, finished_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= kvsl_pkg::PH_HEAD;
			in_word_q  <= 1'b0;
			key_pos_q  <= '0;
			key_eq_q   <= 1'b1;
			matched_q  <= 1'b0;
			emitted_q  <= '0;
			finished_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_n;
			in_word_q  <= in_word_n;
			key_pos_q  <= key_pos_n;
			key_eq_q   <= key_eq_n;
			matched_q  <= matched_n;
			emitted_q  <= emitted_n;
			finished_q <= finished_n;
		end
	end

	kvsl_pkg::char_class_t             cl;
	logic [kvsl_pkg::KEY_POS_W-1:0]    klen;
	logic                              end_str;
	logic                              do_fail;
	logic                              do_emit;
	logic                              do_cmp;
	logic                              cmp_start;
	logic [kvsl_pkg::KEY_POS_W-1:0]    cmp_pos;
	logic                              cmp_miss;

	always_comb begin
		cl        = kvsl_pkg::classify(ch);
		klen      = kvsl_pkg::key_len_eff(cfg.key_length);
		end_str   = eot || (ch == kvsl_pkg::CHAR_NUL);
		do_fail   = 1'b0;
		do_emit   = 1'b0;
		do_cmp    = 1'b0;
		cmp_start = 1'b0;

		phase_n    = phase_q;
		in_word_n  = in_word_q;
		key_pos_n  = key_pos_q;
		key_eq_n   = key_eq_q;
		matched_n  = matched_q;
		emitted_n  = emitted_q;
		finished_n = finished_q;
		res_vld    = 1'b0;
		res        = '0;

		if (ch != kvsl_pkg::CHAR_NUL && !finished_q) begin
			unique case (phase_q)
				kvsl_pkg::PH_HEAD: begin
					if (cfg.lookup_mode) begin
						// Head mode: the first word is the result.
						if (cl == kvsl_pkg::CL_WORD) begin
							phase_n   = kvsl_pkg::PH_EMIT;
							in_word_n = 1'b1;
							do_emit   = 1'b1;
						end else if (cl != kvsl_pkg::CL_SPACE) begin
							do_fail = 1'b1;
						end
					end else if (in_word_q) begin
						if (cl != kvsl_pkg::CL_WORD) begin
							in_word_n = 1'b0;
							phase_n   = kvsl_pkg::PH_COMMA;
							if (cl == kvsl_pkg::CL_COMMA)
								phase_n = kvsl_pkg::PH_KEY;
							else if (cl == kvsl_pkg::CL_EQ)
								do_fail = 1'b1;
						end
					end else if (cl == kvsl_pkg::CL_WORD) begin
						in_word_n = 1'b1;
					end else if (cl != kvsl_pkg::CL_SPACE) begin
						// A punctuation head is skipped as a token of its own.
						phase_n = kvsl_pkg::PH_COMMA;
					end
				end
				kvsl_pkg::PH_COMMA: begin
					if (cl == kvsl_pkg::CL_COMMA)
						phase_n = kvsl_pkg::PH_KEY;
					else if (cl != kvsl_pkg::CL_SPACE)
						do_fail = 1'b1;
				end
				kvsl_pkg::PH_KEY: begin
					if (in_word_q) begin
						if (cl == kvsl_pkg::CL_WORD) begin
							do_cmp = 1'b1;
						end else begin
							in_word_n = 1'b0;
							matched_n = key_eq_q && (klen != '0) && (key_pos_q == klen);
							phase_n   = kvsl_pkg::PH_EQ;
							if (cl == kvsl_pkg::CL_EQ)
								phase_n = kvsl_pkg::PH_VALUE;
							else if (cl == kvsl_pkg::CL_COMMA)
								do_fail = 1'b1;
						end
					end else if (cl == kvsl_pkg::CL_WORD) begin
						in_word_n = 1'b1;
						do_cmp    = 1'b1;
						cmp_start = 1'b1;
					end else if (cl != kvsl_pkg::CL_SPACE) begin
						do_fail = 1'b1;
					end
				end
				kvsl_pkg::PH_EQ: begin
					if (cl == kvsl_pkg::CL_EQ)
						phase_n = kvsl_pkg::PH_VALUE;
					else if (cl != kvsl_pkg::CL_SPACE)
						do_fail = 1'b1;
				end
				kvsl_pkg::PH_VALUE: begin
					if (in_word_q) begin
						if (cl != kvsl_pkg::CL_WORD) begin
							in_word_n = 1'b0;
							phase_n   = kvsl_pkg::PH_COMMA;
							if (cl == kvsl_pkg::CL_COMMA)
								phase_n = kvsl_pkg::PH_KEY;
							else if (cl == kvsl_pkg::CL_EQ)
								do_fail = 1'b1;
						end
					end else if (cl == kvsl_pkg::CL_WORD) begin
						in_word_n = 1'b1;
						if (matched_q) begin
							phase_n = kvsl_pkg::PH_EMIT;
							do_emit = 1'b1;
						end
					end else if (cl != kvsl_pkg::CL_SPACE) begin
						do_fail = 1'b1;
					end
				end
				kvsl_pkg::PH_EMIT: begin
					if (cl == kvsl_pkg::CL_WORD) begin
						do_emit = 1'b1;
					end else begin
						finished_n     = 1'b1;
						res_vld        = 1'b1;
						res.found      = 1'b1;
						res.is_last    = 1'b1;
					end
				end
				default: do_fail = 1'b1;
			endcase
		end

		// Key character compare; a new key word starts over at position zero.
		cmp_pos  = cmp_start ? '0 : key_pos_q;
		cmp_miss = (cmp_pos >= klen) ||
			(ch != kvsl_pkg::key_byte(cfg.key_chars, cmp_pos[kvsl_pkg::KEY_IDX_W-1:0]));
		if (do_cmp) begin
			key_eq_n  = (cmp_start || key_eq_q) && !cmp_miss;
			key_pos_n = (cmp_pos != '1) ? cmp_pos + 1'b1 : cmp_pos;
		end

		if (do_fail) begin
			finished_n  = 1'b1;
			res_vld     = 1'b1;
			res.is_last = 1'b1;
		end

		if (do_emit && (emitted_q < cfg.value_limit)) begin
			emitted_n      = emitted_q + 8'd1;
			res_vld        = 1'b1;
			res.value_byte = ch;
			res.byte_valid = 1'b1;
			res.found      = 1'b1;
		end

		if (end_str) begin
			if (!finished_n) begin
				if (phase_n == kvsl_pkg::PH_EMIT) begin
					if (res_vld) begin
						res.is_last = 1'b1;
					end else begin
						res_vld     = 1'b1;
						res.found   = 1'b1;
						res.is_last = 1'b1;
					end
				end else begin
					res_vld     = 1'b1;
					res.is_last = 1'b1;
				end
			end
			phase_n    = kvsl_pkg::PH_HEAD;
			in_word_n  = 1'b0;
			key_pos_n  = '0;
			key_eq_n   = 1'b1;
			matched_n  = 1'b0;
			emitted_n  = '0;
			finished_n = 1'b0;
		end
	end

endmodule

// ----- rtl/core/kvsl_out_reg.sv -----
// ---------------------------------------------------------------------------
// kvsl_out_reg
// Result register that holds a beat until the receiver takes it.
// ---------------------------------------------------------------------------
module kvsl_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  kvsl_pkg::result_t res,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [7:0]        value_byte,
	output logic              byte_valid,
	output logic              found,
	output logic              is_last
);

	logic              valid_q;
	kvsl_pkg::result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign out_valid  = valid_q;
	assign value_byte = res_q.value_byte;
	assign byte_valid = res_q.byte_valid;
	assign found      = res_q.found;
	assign is_last    = res_q.is_last;

endmodule

// ----- rtl/core/kvsl_checker.sv -----
// ---------------------------------------------------------------------------
// kvsl_checker
// Port-level checks on the result channel of the lookup block.
// ---------------------------------------------------------------------------
`include "key_value_string_lookup_assert.svh"

module kvsl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] value_byte,
	input logic       byte_valid,
	input logic       found,
	input logic       is_last
);

	// A stalled beat stays on the port unchanged.
	`KVSL_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable({value_byte, byte_valid, found, is_last}))

	// Every beat without data closes the string.
	`KVSL_ASSERT_SAME(a_nodata_last, out_valid && !byte_valid, is_last)

	// Data bytes only ever belong to a match.
	`KVSL_ASSERT_SAME(a_data_found, out_valid && byte_valid, found)

	// A beat without data carries a zero byte.
	`KVSL_ASSERT_SAME(a_nodata_zero, out_valid && !byte_valid, value_byte == 8'd0)

endmodule

bind key_value_string_lookup kvsl_checker u_kvsl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.value_byte (value_byte),
	.byte_valid (byte_valid),
	.found      (found),
	.is_last    (is_last)
);
